@@ design/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

    localparam int NUM_VARS    = 64;
    localparam int NUM_CLAUSES = 64;
    localparam int VAW         = $clog2(NUM_VARS);
    localparam int CAW         = $clog2(NUM_CLAUSES);
    localparam int CNTW        = 7;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_ASSIGN   = 3'd1,
        CMD_UNASSIGN = 3'd2,
        CMD_COUNT    = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_UNIT_RD,
        S_UNIT_EX,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]      command;
        logic [VAW-1:0]  var_index;
        logic [CAW-1:0]  clause_index;
        logic            is_positive;
        logic            assign_value;
        logic [CNTW-1:0] free_limit;
    } t_in;

    typedef struct packed {
        logic            unit_valid;
        logic [VAW-1:0]  unit_var;
        logic [CAW-1:0]  reason_clause;
        logic [CNTW-1:0] pos_count;
        logic [CNTW-1:0] neg_count;
        logic            conflict;
        logic            all_sat;
        logic            last;
    } t_out;

    typedef struct packed {
        logic [NUM_VARS-1:0] pos;
        logic [NUM_VARS-1:0] neg;
        logic [NUM_VARS-1:0] uns;
        logic [NUM_VARS-1:0] sat;
    } t_clause;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [NUM_VARS-1:0] bitsel;
        logic                is_target;
        logic                is_positive;
        logic                side_val;
        logic                go;
        logic                in_use;
        logic [CNTW-1:0]     limit;
    } t_eval_ctl;

    typedef struct packed {
        t_clause        rec;
        logic           conflict_hit;
        logic           unsat;
        logic           pos_hit;
        logic           neg_hit;
        logic           unit;
        logic [VAW-1:0] unit_var;
    } t_eval_res;

endpackage

@@ design/sat_clause_propagation_engine.sv @@
`timescale 1ns / 1ps
// sequence: every command sweeps the clause memory once, then loads the result register;
//   an assign that is taken adds a second walk with one memory read and one evaluate
//   per clause, plus any output stall
// commands: one at a time, the next is taken only once the last is done; the pace is set by the
//   single read port of the clause memory and the one shared clause evaluator
// reset: synchronous active low; clears control, conflict, variable flags and the
//   per-entry valid bits of the clause memory, so no clearing pass is needed
module sat_clause_propagation_engine
    import scp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in             i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out            o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CNTW-1:0] i_cfg_data
);

    localparam logic [CNTW-1:0] CLAUSE_END = CNTW'(NUM_CLAUSES);
    localparam logic [CAW-1:0]  LAST_ADDR  = CAW'(NUM_CLAUSES - 1);

    // sequencer and command context
    t_state              r_state, n_state;
    t_in                 r_cmd;
    logic                r_go;
    logic                r_side;
    logic [CNTW-1:0]     r_cfg;
    logic [NUM_VARS-1:0] r_free;
    logic [NUM_VARS-1:0] r_val;
    logic                r_conf;
    logic                r_allsat;
    logic [CNTW-1:0]     r_pc;
    logic [CNTW-1:0]     r_nc;

    // sweep pointers: r_addr is the read address, r_pa the address of the data
    // now at the memory output during the pipelined sweep
    logic [CNTW-1:0]     r_addr;
    logic                r_dv;
    logic [CAW-1:0]      r_pa;

    // one unit implication is held back so the final one can be marked last
    logic                r_hold_has;
    logic [VAW-1:0]      r_hold_var;
    logic [CAW-1:0]      r_hold_cl;

    t_out                r_out;
    logic                r_ovalid;

    logic                in_acc;
    logic                out_free;
    logic [CNTW-1:0]     active_n;
    logic [CAW-1:0]      ev_addr;
    t_eval_ctl           ev_ctl;
    t_eval_res           ev_res;
    t_clause             rd_data;
    logic                rd_en;
    logic [CAW-1:0]      rd_addr;
    logic                wr_en;
    logic                stall;
    logic                emit_hold;
    logic                emit_final;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;
    assign active_n    = (r_cfg > CLAUSE_END) ? CLAUSE_END : r_cfg;

    // the evaluator looks at the pipelined data in the sweep, at the read address later
    assign ev_addr = (r_state == S_SWEEP) ? r_pa : r_addr[CAW-1:0];

    always_comb begin
        ev_ctl.cmd         = r_cmd.command;
        ev_ctl.bitsel      = NUM_VARS'(1) << r_cmd.var_index;
        ev_ctl.is_target   = (ev_addr == r_cmd.clause_index);
        ev_ctl.is_positive = r_cmd.is_positive;
        ev_ctl.side_val    = r_side;
        ev_ctl.go          = r_go;
        ev_ctl.in_use      = ({1'b0, ev_addr} < active_n);
        ev_ctl.limit       = r_cmd.free_limit;
    end

    scp_clause_eval u_eval (
        .i_rec (rd_data),
        .i_ctl (ev_ctl),
        .o_res (ev_res)
    );

    scp_clause_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_pa),
        .i_wr_data (ev_res.rec),
        .o_rd_data (rd_data)
    );

    assign stall = ev_res.unit && r_hold_has && !out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (!r_dv && (r_addr == CLAUSE_END)) begin
                    if ((t_cmd'(r_cmd.command) == CMD_ASSIGN) && r_go) begin
                        n_state = S_UNIT_RD;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_UNIT_RD: begin
                n_state = S_UNIT_EX;
            end
            S_UNIT_EX: begin
                if (!stall) begin
                    n_state = (r_addr[CAW-1:0] == LAST_ADDR) ? S_FLUSH : S_UNIT_RD;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = r_addr[CAW-1:0];
        wr_en      = 1'b0;
        emit_hold  = 1'b0;
        emit_final = 1'b0;
        case (r_state)
            S_SWEEP: begin
                rd_en = (r_addr != CLAUSE_END);
                wr_en = r_dv;
            end
            S_UNIT_RD: begin
                rd_en = 1'b1;
            end
            S_UNIT_EX: begin
                emit_hold = ev_res.unit && r_hold_has && out_free;
            end
            S_FLUSH: begin
                emit_final = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= '0;
            r_free     <= '1;
            r_val      <= '0;
            r_conf     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_hold_has <= 1'b0;
            r_dv       <= 1'b0;
            r_addr     <= '0;
            r_go       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd    <= i_in_data;
                        r_addr   <= '0;
                        r_dv     <= 1'b0;
                        r_allsat <= 1'b1;
                        r_pc     <= '0;
                        r_nc     <= '0;
                        r_go     <= 1'b0;
                        r_side   <= 1'b0;
                        case (t_cmd'(i_in_data.command))
                            CMD_ASSIGN: begin
                                // an assigned variable ignores a second assign
                                r_go   <= r_free[i_in_data.var_index];
                                r_side <= i_in_data.assign_value;
                                if (r_free[i_in_data.var_index]) begin
                                    r_free[i_in_data.var_index] <= 1'b0;
                                    r_val[i_in_data.var_index]  <= i_in_data.assign_value;
                                end
                            end
                            CMD_UNASSIGN: begin
                                // uses the stored value even if already free
                                r_side <= r_val[i_in_data.var_index];
                                r_free[i_in_data.var_index] <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                r_conf <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    r_dv <= rd_en;
                    r_pa <= r_addr[CAW-1:0];
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_dv) begin
                        if (ev_res.conflict_hit) begin
                            r_conf <= 1'b1;
                        end
                        if (ev_res.unsat) begin
                            r_allsat <= 1'b0;
                        end
                        r_pc <= r_pc + CNTW'(ev_res.pos_hit);
                        r_nc <= r_nc + CNTW'(ev_res.neg_hit);
                    end
                    if (n_state == S_UNIT_RD) begin
                        r_addr <= '0;
                    end
                end
                S_UNIT_EX: begin
                    if (!stall) begin
                        r_addr <= r_addr + 1'b1;
                        if (ev_res.unit) begin
                            r_hold_has <= 1'b1;
                            r_hold_var <= ev_res.unit_var;
                            r_hold_cl  <= r_addr[CAW-1:0];
                        end
                    end
                end
                S_FLUSH: begin
                    if (emit_final) begin
                        r_hold_has <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // a new transaction loads the result register, otherwise it drains
            if (emit_hold || emit_final) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (emit_hold || emit_final) begin
            r_out.conflict <= r_conf;
            r_out.all_sat  <= r_allsat;
            r_out.last     <= emit_final;
            if (r_hold_has) begin
                r_out.unit_valid    <= 1'b1;
                r_out.unit_var      <= r_hold_var;
                r_out.reason_clause <= r_hold_cl;
                r_out.pos_count     <= '0;
                r_out.neg_count     <= '0;
            end else begin
                // status transaction, counts are zero outside the count command
                r_out.unit_valid    <= 1'b0;
                r_out.unit_var      <= '0;
                r_out.reason_clause <= '0;
                r_out.pos_count     <= r_pc;
                r_out.neg_count     <= r_nc;
            end
        end
    end

endmodule

@@ design/scp_clause_ram.sv @@
`timescale 1ns / 1ps
module scp_clause_ram
    import scp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [CAW-1:0] i_rd_addr,
    input  logic           i_wr_en,
    input  logic [CAW-1:0] i_wr_addr,
    input  t_clause        i_wr_data,
    output t_clause        o_rd_data
);

    t_clause                r_mem [NUM_CLAUSES];
    logic [NUM_CLAUSES-1:0] r_valid;
    t_clause                r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // entries never written read as empty clauses
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/scp_clause_eval.sv @@
`timescale 1ns / 1ps
module scp_clause_eval
    import scp_pkg::*;
(
    input  t_clause   i_rec,
    input  t_eval_ctl i_ctl,
    output t_eval_res o_res
);

    function automatic logic [CNTW-1:0] popcount(input logic [NUM_VARS-1:0] v);
        logic [CNTW-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_VARS; i++) begin
            n = n + CNTW'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [VAW-1:0] lowest(input logic [NUM_VARS-1:0] v);
        logic [VAW-1:0] idx;
        idx = '0;
        for (int i = NUM_VARS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = VAW'(i);
            end
        end
        return idx;
    endfunction

    t_clause             rec;
    logic [NUM_VARS-1:0] side;
    logic [NUM_VARS-1:0] other;
    logic                one_left;

    always_comb begin
        rec   = i_rec;
        side  = i_ctl.side_val ? i_rec.pos : i_rec.neg;
        other = i_ctl.side_val ? i_rec.neg : i_rec.pos;
        case (t_cmd'(i_ctl.cmd))
            CMD_ADD: begin
                if (i_ctl.is_target) begin
                    if (i_ctl.is_positive) begin
                        rec.pos = rec.pos | i_ctl.bitsel;
                    end else begin
                        rec.neg = rec.neg | i_ctl.bitsel;
                    end
                    rec.uns = rec.uns | i_ctl.bitsel;
                end
            end
            CMD_ASSIGN: begin
                if (i_ctl.go) begin
                    if ((side & i_ctl.bitsel) != '0) begin
                        rec.uns = rec.uns & ~i_ctl.bitsel;
                        rec.sat = rec.sat | i_ctl.bitsel;
                    end
                    if ((other & i_ctl.bitsel) != '0) begin
                        rec.uns = rec.uns & ~i_ctl.bitsel;
                    end
                end
            end
            CMD_UNASSIGN: begin
                if ((side & i_ctl.bitsel) != '0) begin
                    rec.sat = rec.sat & ~i_ctl.bitsel;
                end
                if (((rec.pos | rec.neg) & i_ctl.bitsel) != '0) begin
                    rec.uns = rec.uns | i_ctl.bitsel;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        one_left           = (rec.uns != '0) && ((rec.uns & (rec.uns - 1'b1)) == '0);
        o_res.rec          = rec;
        o_res.unsat        = i_ctl.in_use && (rec.sat == '0);
        o_res.conflict_hit = (t_cmd'(i_ctl.cmd) == CMD_ASSIGN) && i_ctl.go && o_res.unsat
                             && ((other & i_ctl.bitsel) != '0) && (rec.uns == '0);
        o_res.unit         = (t_cmd'(i_ctl.cmd) == CMD_ASSIGN) && i_ctl.go && o_res.unsat
                             && ((other & i_ctl.bitsel) != '0) && one_left;
        o_res.unit_var     = lowest(rec.uns);
        o_res.pos_hit      = (t_cmd'(i_ctl.cmd) == CMD_COUNT) && o_res.unsat
                             && (popcount(rec.uns) <= i_ctl.limit)
                             && ((rec.pos & i_ctl.bitsel) != '0);
        o_res.neg_hit      = (t_cmd'(i_ctl.cmd) == CMD_COUNT) && o_res.unsat
                             && (popcount(rec.uns) <= i_ctl.limit)
                             && ((rec.neg & i_ctl.bitsel) != '0);
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import scp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_LEN       = 1500;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in             i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out            o_out_data;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CNTW-1:0] i_cfg_data;

    sat_clause_propagation_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // clause table mirror
    logic [NUM_VARS-1:0] m_pos [NUM_CLAUSES] = '{default: '0};
    logic [NUM_VARS-1:0] m_neg [NUM_CLAUSES] = '{default: '0};
    logic [NUM_VARS-1:0] m_uns [NUM_CLAUSES] = '{default: '0};
    logic [NUM_VARS-1:0] m_sat [NUM_CLAUSES] = '{default: '0};
    logic [NUM_VARS-1:0] m_free = '1;
    logic [NUM_VARS-1:0] m_val = '0;
    logic                m_conflict = 1'b0;
    int                  m_in_use;

    t_in  cmd_q [$];
    t_out result_q [$];
    logic [CNTW-1:0] cfg_q [$];

    int  errors;
    int  n_results;
    int  n_units;
    int  idle_pct;      // driver idle percentage
    int  sink_idle_pct;
    int  hold_cycles;   // long receiver stall
    bit  hold_req;
    bit  hold_taken;
    int  quiet;
    bit  drain_req;

    task automatic queue_cmd(input t_in it);
        cmd_q = {cmd_q, it};
    endtask

    function automatic int popcnt(logic [NUM_VARS-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < NUM_VARS; i++) n += int'(v[i]);
        return n;
    endfunction

    function automatic int lowest(logic [NUM_VARS-1:0] v);
        for (int i = 0; i < NUM_VARS; i++) if (v[i]) return i;
        return 0;
    endfunction

    function automatic bit every_clause_sat();
        for (int c = 0; c < m_in_use; c++) if (m_sat[c] == '0) return 0;
        return 1;
    endfunction

    // advance the mirror by one command and queue the results it causes
    task automatic propagate(input t_in it);
        logic [NUM_VARS-1:0] b;
        int  k;
        int  pc;
        int  nc;
        int  first;
        t_out r;
        b = '0;
        b[it.var_index] = 1'b1;
        k = 0;
        pc = 0;
        nc = 0;
        first = result_q.size();
        case (it.command)
            CMD_ADD: begin
                if (it.is_positive) m_pos[it.clause_index] |= b;
                else m_neg[it.clause_index] |= b;
                m_uns[it.clause_index] |= b;
            end
            CMD_ASSIGN: begin
                if (m_free[it.var_index]) begin
                    m_free[it.var_index] = 1'b0;
                    m_val[it.var_index] = it.assign_value;
                    for (int c = 0; c < NUM_CLAUSES; c++) begin
                        if (((it.assign_value ? m_pos[c] : m_neg[c]) & b) != '0) begin
                            m_uns[c] &= ~b;
                            m_sat[c] |= b;
                        end
                    end
                    for (int c = 0; c < NUM_CLAUSES; c++) begin
                        if (((it.assign_value ? m_neg[c] : m_pos[c]) & b) != '0) begin
                            m_uns[c] &= ~b;
                            if (c < m_in_use && m_sat[c] == '0 && m_uns[c] == '0)
                                m_conflict = 1'b1;
                        end
                    end
                    for (int c = 0; c < m_in_use; c++) begin
                        if (((it.assign_value ? m_neg[c] : m_pos[c]) & b) != '0
                            && m_sat[c] == '0 && popcnt(m_uns[c]) == 1) begin
                            r = '0;
                            r.unit_valid = 1'b1;
                            r.unit_var = VAW'(lowest(m_uns[c]));
                            r.reason_clause = CAW'(c);
                            result_q = {result_q, r};
                            k++;
                        end
                    end
                end
            end
            CMD_UNASSIGN: begin
                m_free[it.var_index] = 1'b1;
                for (int c = 0; c < NUM_CLAUSES; c++) begin
                    if (((m_val[it.var_index] ? m_pos[c] : m_neg[c]) & b) != '0)
                        m_sat[c] &= ~b;
                    if (((m_pos[c] | m_neg[c]) & b) != '0) m_uns[c] |= b;
                end
            end
            CMD_COUNT: begin
                for (int c = 0; c < m_in_use; c++) begin
                    if (m_sat[c] == '0 && popcnt(m_uns[c]) <= it.free_limit) begin
                        if ((m_pos[c] & b) != '0) pc++;
                        if ((m_neg[c] & b) != '0) nc++;
                    end
                end
            end
            CMD_CLEAR: m_conflict = 1'b0;
            default: ;
        endcase
        if (k == 0) begin
            r = '0;
            r.pos_count = CNTW'(pc);
            r.neg_count = CNTW'(nc);
            result_q = {result_q, r};
        end
        // status fields reflect the state after the whole command
        for (int i = first; i < result_q.size(); i++) begin
            r = result_q[i];
            r.conflict = m_conflict;
            r.all_sat = every_clause_sat();
            r.last = (i == result_q.size() - 1);
            result_q[i] = r;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one command transaction at a time from cmd_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) propagate(i_in_data);
            if (cmd_q.size() > 0 && !drain_req && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= cmd_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // configuration write transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            i_cfg_data <= '0;
        end else if (!i_cfg_valid || o_cfg_ready) begin
            if (i_cfg_valid)
                m_in_use = (i_cfg_data > CNTW'(NUM_CLAUSES)) ? NUM_CLAUSES : int'(i_cfg_data);
            if (cfg_q.size() > 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_data <= cfg_q.pop_front();
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // monitor and result sink
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    $error("unexpected result %p", o_out_data);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.unit_valid) n_units++;
                    if (o_out_data.unit_valid !== exp_r.unit_valid) begin
                        $error("unit_valid exp %0d got %0d", exp_r.unit_valid,
                               o_out_data.unit_valid); errors++; end
                    if (o_out_data.unit_var !== exp_r.unit_var) begin
                        $error("unit_var exp %0d got %0d", exp_r.unit_var,
                               o_out_data.unit_var); errors++; end
                    if (o_out_data.reason_clause !== exp_r.reason_clause) begin
                        $error("reason_clause exp %0d got %0d", exp_r.reason_clause,
                               o_out_data.reason_clause); errors++; end
                    if (o_out_data.pos_count !== exp_r.pos_count) begin
                        $error("pos_count exp %0d got %0d", exp_r.pos_count,
                               o_out_data.pos_count); errors++; end
                    if (o_out_data.neg_count !== exp_r.neg_count) begin
                        $error("neg_count exp %0d got %0d", exp_r.neg_count,
                               o_out_data.neg_count); errors++; end
                    if (o_out_data.conflict !== exp_r.conflict) begin
                        $error("conflict exp %0d got %0d", exp_r.conflict,
                               o_out_data.conflict); errors++; end
                    if (o_out_data.all_sat !== exp_r.all_sat) begin
                        $error("all_sat exp %0d got %0d", exp_r.all_sat,
                               o_out_data.all_sat); errors++; end
                    if (o_out_data.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last,
                               o_out_data.last); errors++; end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                // one long receiver stall, counted here
                hold_taken = 1'b1;
                hold_cycles = HOLD_LEN - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_in mk(t_cmd c, int v, int cl, int p, int a, int lim);
        t_in it;
        it.command = c;
        it.var_index = VAW'(v);
        it.clause_index = CAW'(cl);
        it.is_positive = p[0];
        it.assign_value = a[0];
        it.free_limit = CNTW'(lim);
        return it;
    endfunction

    task automatic settle();
        while (cmd_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int v);
        settle();
        cfg_q = {cfg_q, CNTW'(v)};
        while (cfg_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // random formula: adds to clauses 0 to 7 mixed with assignments and probes
    task automatic random_phase(input int n, input int nv);
        t_in it;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: it = mk(CMD_ADD, $urandom_range(nv - 1), $urandom_range(7),
                                 $urandom_range(1), $urandom_range(1), $urandom);
                3, 4, 5: it = mk(CMD_ASSIGN, $urandom_range(nv - 1), $urandom,
                                 $urandom_range(1), $urandom_range(1), $urandom);
                6: it = mk(CMD_UNASSIGN, $urandom_range(nv - 1), $urandom,
                           $urandom_range(1), $urandom_range(1), $urandom);
                7: it = mk(CMD_COUNT, $urandom_range(nv - 1), $urandom,
                           $urandom_range(1), $urandom_range(1), $urandom_range(127));
                8: it = mk(CMD_CLEAR, $urandom, $urandom, $urandom_range(1),
                           $urandom_range(1), $urandom);
                default: begin
                    it = mk(CMD_ADD, $urandom_range(63), $urandom_range(63),
                            $urandom_range(1), $urandom_range(1), $urandom_range(127));
                    it.command = 3'(5 + $urandom_range(2));
                end
            endcase
            queue_cmd(it);
        end
    endtask

    initial begin
        idle_pct = 30;
        sink_idle_pct = 30;
        drain_req = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no clauses in use, then a two-clause formula at the extremes
        queue_cmd(mk(CMD_COUNT, 0, 0, 0, 0, 0));
        write_cfg(127);
        queue_cmd(mk(CMD_ADD, 0, 0, 1, 0, 0));
        queue_cmd(mk(CMD_ADD, 63, 0, 0, 0, 0));
        queue_cmd(mk(CMD_ADD, 63, 63, 1, 0, 0));
        queue_cmd(mk(CMD_ADD, 5, 63, 1, 0, 0));
        queue_cmd(mk(CMD_COUNT, 63, 0, 0, 0, 127));
        queue_cmd(mk(CMD_COUNT, 63, 0, 0, 0, 1));
        queue_cmd(mk(CMD_ASSIGN, 0, 0, 0, 0, 0));   // clause 0 becomes unit
        queue_cmd(mk(CMD_ASSIGN, 0, 0, 0, 1, 0));   // already assigned
        queue_cmd(mk(CMD_ASSIGN, 63, 0, 0, 1, 0));  // conflict in clause 0
        queue_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
        queue_cmd(mk(CMD_ADD, 63, 1, 1, 0, 0));     // add to assigned variable
        queue_cmd(mk(CMD_UNASSIGN, 63, 0, 0, 0, 0));
        queue_cmd(mk(CMD_UNASSIGN, 10, 0, 0, 0, 0)); // free variable
        queue_cmd(mk(CMD_ASSIGN, 5, 0, 0, 1, 0));
        queue_cmd(mk(CMD_COUNT, 0, 0, 0, 0, 64));
        queue_cmd(t_in'({3'd7, 6'd1, 6'd1, 1'b1, 1'b1, 7'd127}));
        write_cfg(1);
        queue_cmd(mk(CMD_UNASSIGN, 0, 0, 0, 0, 0));
        queue_cmd(mk(CMD_ASSIGN, 0, 0, 0, 1, 0));
        queue_cmd(mk(CMD_COUNT, 5, 0, 0, 0, 127));

        // unit burst: many clauses with var 1 negated and one of vars 4 to 17 positive
        write_cfg(64);
        for (int c = 8; c < 64; c += 4) begin
            queue_cmd(mk(CMD_ADD, 1, c, 0, 0, 0));
            queue_cmd(mk(CMD_ADD, 2 + c / 4, c, 1, 0, 0));
        end
        // receiver stalls long while the sender keeps offering
        settle();
        hold_req = 1'b1;
        queue_cmd(mk(CMD_ASSIGN, 1, 0, 0, 1, 0));
        queue_cmd(mk(CMD_COUNT, 1, 0, 0, 0, 127));
        queue_cmd(mk(CMD_UNASSIGN, 1, 0, 0, 0, 0));
        queue_cmd(mk(CMD_COUNT, 2, 0, 0, 0, 2));

        // random phases with no idling, then with idling, then with four clauses in use
        settle();
        idle_pct = 0;
        sink_idle_pct = 0;
        random_phase(25, 16);
        settle();
        idle_pct = 30;
        sink_idle_pct = 30;
        random_phase(25, 64);
        write_cfg(4);
        random_phase(26, 8);
        settle();
        write_cfg(0);
        queue_cmd(mk(CMD_COUNT, 3, 0, 0, 0, 127));
        settle();

        $display("ran %0d results, %0d unit implications, over table sizes 0 to 127",
                 n_results, n_units);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
